// ===== src/jsv_pkg.sv =====
// Package: shared types, codes and constants of the JSON syntax validator.
package jsv_pkg;

    localparam int unsigned DefMaxDepth = 64;

    typedef enum logic [2:0] {
        ST_RUN   = 3'd0,
        ST_OK    = 3'd1,
        ST_EMPTY = 3'd2,
        ST_BAD   = 3'd3,
        ST_EARLY = 3'd4,
        ST_CTRL  = 3'd5,
        ST_UNI   = 3'd6,
        ST_DEEP  = 3'd7
    } t_status;

    typedef enum logic [4:0] {
        G_TOP       = 5'd0,
        G_VALUE     = 5'd1,
        G_ARR_FIRST = 5'd2,
        G_OBJ_FIRST = 5'd3,
        G_OBJ_KEY   = 5'd4,
        G_COLON     = 5'd5,
        G_AFTER     = 5'd6,
        G_TRAIL     = 5'd7,
        G_STR_V     = 5'd8,
        G_ESC_V     = 5'd9,
        G_HEX_V     = 5'd10,
        G_STR_K     = 5'd11,
        G_ESC_K     = 5'd12,
        G_HEX_K     = 5'd13,
        G_N_MINUS   = 5'd14,
        G_N_ZERO    = 5'd15,
        G_N_INT     = 5'd16,
        G_N_DOT     = 5'd17,
        G_N_FRAC    = 5'd18,
        G_N_E       = 5'd19,
        G_N_ESIGN   = 5'd20,
        G_N_EXP     = 5'd21,
        G_LIT       = 5'd22
    } t_gstate;

    // Byte class computed by the front end
    typedef struct packed {
        logic [7:0] c;
        logic       eot;
        logic       ws;
        logic       dig;
        logic       expo;
        logic       hex;
        logic [3:0] hexv;
        logic       ctrl;
        logic       simple_esc;
    } t_cls;

    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] i);
        logic [7:0] r;
        r = 8'h00;
        case (k)
            LIT_TRUE: begin
                case (i)
                    3'd1: r = "r";
                    3'd2: r = "u";
                    3'd3: r = "e";
                    default: r = 8'h00;
                endcase
            end
            LIT_FALSE: begin
                case (i)
                    3'd1: r = "a";
                    3'd2: r = "l";
                    3'd3: r = "s";
                    3'd4: r = "e";
                    default: r = 8'h00;
                endcase
            end
            default: begin
                case (i)
                    3'd1: r = "u";
                    3'd2: r = "l";
                    3'd3: r = "l";
                    default: r = 8'h00;
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] k);
        return (k == LIT_FALSE) ? 3'd5 : 3'd4;
    endfunction

endpackage

// ===== src/jsv_if.sv =====
// Interfaces: valid/ready channels for text bytes and results.
interface jsv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;
    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jsv_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] error_position;
    modport source (output valid, output status, output error_position, input ready);
    modport sink (input valid, input status, input error_position, output ready);
endinterface

// ===== src/json_syntax_validator_unit.sv =====
// Top level: JSON syntax validator with a byte queue in front of the checker.
// Usage:
//   i_in carries one document byte per transaction; end_of_text marks the last.
//   o_out carries one result per byte: status and error_position.
//   i_cfg_we/i_cfg_wdata write require_container while the block is idle.
// Path: an accepted byte is held in the front queue, then its result lands
// in the checker's output register.
// Throughput: one byte per cycle while o_out is not held; the checker handles each
// byte, including a byte that ends a number and is rechecked, in the cycle it is taken.
// Reset: the queue empties, the grammar returns to expect-top-level and
// require_container returns to 1. After each end of text the document state
// clears by itself.
// Stall: while o_out is held the result register keeps its transaction; the
// two-entry queue absorbs further bytes, then i_in.ready falls.
module json_syntax_validator_unit #(
    parameter int unsigned MAX_DEPTH = jsv_pkg::DefMaxDepth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    jsv_in_if.sink     i_in,
    jsv_out_if.source  o_out
);
    logic          w_valid, w_ready;
    jsv_pkg::t_cls w_cls;

    jsv_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in),
        .o_valid(w_valid), .o_cls(w_cls), .i_ready(w_ready)
    );

    jsv_back #(.MAX_DEPTH(MAX_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata), .i_valid(w_valid), .i_cls(w_cls),
        .o_ready(w_ready), .o_out(o_out)
    );

`ifndef SYNTHESIS
    a_early_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status == jsv_pkg::ST_EARLY |-> o_out.error_position != 32'd0)
        else $error("early end reported at position zero");
    a_clean_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status == jsv_pkg::ST_RUN || o_out.status == jsv_pkg::ST_OK ||
        o_out.status == jsv_pkg::ST_EMPTY) |-> o_out.error_position == 32'd0)
        else $error("non-error result carries a position");
    a_no_out_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid straight after reset");
`endif
endmodule

// ===== src/jsv_front.sv =====
// Front end: accepts bytes, classifies them and queues them for the checker.
module jsv_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    jsv_in_if.sink               i_in,
    output logic                 o_valid,
    output jsv_pkg::t_cls        o_cls,
    input  logic                 i_ready
);
    localparam int Depth = 2;

    jsv_pkg::t_cls r_q [Depth];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    jsv_pkg::t_cls w_cls;
    logic          w_push, w_pop;
    logic [7:0]    c;

    always_comb begin
        c = i_in.text_byte;
        w_cls.c = c;
        w_cls.eot = i_in.end_of_text;
        w_cls.ws = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
        w_cls.dig = (c >= "0" && c <= "9");
        w_cls.expo = (c == "e") || (c == "E");
        w_cls.ctrl = (c <= 8'd31);
        w_cls.simple_esc = (c == "\"") || (c == "\\") || (c == "/") || (c == "b") ||
                           (c == "f") || (c == "n") || (c == "r") || (c == "t");
        w_cls.hex = 1'b1;
        w_cls.hexv = 4'd0;
        if (c >= "0" && c <= "9") begin
            w_cls.hexv = 4'(c - "0");
        end else if (c >= "a" && c <= "f") begin
            w_cls.hexv = 4'(c - "a" + 8'd10);
        end else if (c >= "A" && c <= "F") begin
            w_cls.hexv = 4'(c - "A" + 8'd10);
        end else begin
            w_cls.hex = 1'b0;
        end
    end

    assign i_in.ready = (r_cnt != 2'(Depth));
    assign w_push = i_in.valid && i_in.ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_cls = r_q[r_rp];
    assign w_pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cls;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

// ===== src/jsv_back.sv =====
// Back end: grammar state machine, container stack and result register.
module jsv_back #(
    parameter int unsigned MAX_DEPTH = jsv_pkg::DefMaxDepth
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  logic          i_valid,
    input  jsv_pkg::t_cls i_cls,
    output logic          o_ready,
    jsv_out_if.source     o_out
);
    localparam int LW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    logic                r_req;
    jsv_pkg::t_gstate    r_gs, n_gs;
    logic [LW-1:0]       r_lvl, n_lvl;
    logic [2:0]          r_li, n_li;
    logic [1:0]          r_lk, n_lk;
    logic [2:0]          r_hc, n_hc;
    logic                r_sur, n_sur;
    jsv_pkg::t_status    r_ls, n_ls;
    logic [31:0]         r_pos, r_epos, n_epos;
    logic                r_top, n_top;
    logic                r_stk [MAX_DEPTH];
    logic                r_below;
    logic [LW-1:0]       w_lvl_next;
    logic [AW-1:0]       w_rd_addr;
    logic                w_push;
    logic                w_push_obj;
    logic                r_ov;
    logic [2:0]          r_ost;
    logic [31:0]         r_opos;
    logic [2:0]          n_ost;
    logic [31:0]         n_opos;
    logic                w_go;

    assign o_ready = !r_ov || o_out.ready;
    assign w_go = i_valid && o_ready;
    assign o_out.valid = r_ov;
    assign o_out.status = r_ost;
    assign o_out.error_position = r_opos;

    // Keep the entry just below the top of the stack ready for a close
    assign w_lvl_next = w_go ? (i_cls.eot ? '0 : n_lvl) : r_lvl;
    assign w_rd_addr = (w_lvl_next >= LW'(2)) ? AW'(w_lvl_next - LW'(2)) : '0;

    always_comb begin
        logic [7:0] c;
        logic       again;
        logic       done_val;
        logic       close_c;
        logic       open_c;
        logic [2:0] hc1;
        c = i_cls.c;
        n_gs = r_gs; n_lvl = r_lvl; n_li = r_li; n_lk = r_lk; n_hc = r_hc;
        n_sur = r_sur; n_ls = r_ls; n_epos = r_epos; n_top = r_top;
        w_push = 1'b0; w_push_obj = 1'b0;
        again = 1'b0; done_val = 1'b0; close_c = 1'b0; open_c = 1'b0;
        hc1 = r_hc + 3'd1;
        if (r_ls == jsv_pkg::ST_RUN) begin
            case (r_gs)
                jsv_pkg::G_TOP, jsv_pkg::G_VALUE, jsv_pkg::G_ARR_FIRST: begin
                    if (!i_cls.ws) begin
                        if (r_gs == jsv_pkg::G_ARR_FIRST && c == "]") close_c = 1'b1;
                        else if (r_gs == jsv_pkg::G_TOP && r_req && c != "{" && c != "[")
                            n_ls = jsv_pkg::ST_BAD;
                        else open_c = 1'b1;
                    end
                end
                jsv_pkg::G_OBJ_FIRST, jsv_pkg::G_OBJ_KEY: begin
                    if (!i_cls.ws) begin
                        if (c == "\"") n_gs = jsv_pkg::G_STR_K;
                        else if (c == "}" && r_gs == jsv_pkg::G_OBJ_FIRST) close_c = 1'b1;
                        else n_ls = jsv_pkg::ST_BAD;
                    end
                end
                jsv_pkg::G_COLON: begin
                    if (!i_cls.ws) begin
                        if (c == ":") n_gs = jsv_pkg::G_VALUE;
                        else n_ls = jsv_pkg::ST_BAD;
                    end
                end
                jsv_pkg::G_AFTER: begin
                    if (!i_cls.ws) begin
                        if (c == ",") n_gs = r_top ? jsv_pkg::G_OBJ_KEY : jsv_pkg::G_VALUE;
                        else if (c == "}" && r_top) close_c = 1'b1;
                        else if (c == "]" && !r_top) close_c = 1'b1;
                        else n_ls = jsv_pkg::ST_BAD;
                    end
                end
                jsv_pkg::G_TRAIL: begin
                    if (!i_cls.ws) n_ls = jsv_pkg::ST_BAD;
                end
                jsv_pkg::G_STR_V, jsv_pkg::G_STR_K: begin
                    if (c == "\"") begin
                        if (r_gs == jsv_pkg::G_STR_K) n_gs = jsv_pkg::G_COLON;
                        else done_val = 1'b1;
                    end else if (i_cls.ctrl) n_ls = jsv_pkg::ST_CTRL;
                    else if (c == "\\")
                        n_gs = (r_gs == jsv_pkg::G_STR_K) ? jsv_pkg::G_ESC_K : jsv_pkg::G_ESC_V;
                end
                jsv_pkg::G_ESC_V, jsv_pkg::G_ESC_K: begin
                    if (i_cls.simple_esc)
                        n_gs = (r_gs == jsv_pkg::G_ESC_K) ? jsv_pkg::G_STR_K : jsv_pkg::G_STR_V;
                    else if (c == "u") begin
                        n_hc = 3'd0; n_sur = 1'b0;
                        n_gs = (r_gs == jsv_pkg::G_ESC_K) ? jsv_pkg::G_HEX_K : jsv_pkg::G_HEX_V;
                    end else n_ls = jsv_pkg::ST_BAD;
                end
                jsv_pkg::G_HEX_V, jsv_pkg::G_HEX_K: begin
                    if (!i_cls.hex) n_ls = jsv_pkg::ST_BAD;
                    else begin
                        if (r_hc == 3'd0) n_sur = (i_cls.hexv == 4'd13);
                        else if (r_hc == 3'd1) n_sur = r_sur && i_cls.hexv[3];
                        n_hc = hc1;
                        if (hc1 >= 3'd4) begin
                            n_hc = 3'd0;
                            if (n_sur) begin
                                n_ls = jsv_pkg::ST_UNI;
                                n_epos = r_pos - 32'd4;
                            end else begin
                                n_gs = (r_gs == jsv_pkg::G_HEX_K) ?
                                       jsv_pkg::G_STR_K : jsv_pkg::G_STR_V;
                            end
                        end
                    end
                end
                jsv_pkg::G_N_MINUS: begin
                    if (c == "0") n_gs = jsv_pkg::G_N_ZERO;
                    else if (i_cls.dig) n_gs = jsv_pkg::G_N_INT;
                    else n_ls = jsv_pkg::ST_BAD;
                end
                jsv_pkg::G_N_ZERO, jsv_pkg::G_N_INT: begin
                    if (i_cls.dig && r_gs == jsv_pkg::G_N_ZERO) n_ls = jsv_pkg::ST_BAD;
                    else if (i_cls.dig) n_gs = r_gs;
                    else if (c == ".") n_gs = jsv_pkg::G_N_DOT;
                    else if (i_cls.expo) n_gs = jsv_pkg::G_N_E;
                    else again = 1'b1;
                end
                jsv_pkg::G_N_DOT: begin
                    if (i_cls.dig) n_gs = jsv_pkg::G_N_FRAC;
                    else n_ls = jsv_pkg::ST_BAD;
                end
                jsv_pkg::G_N_FRAC: begin
                    if (i_cls.expo) n_gs = jsv_pkg::G_N_E;
                    else if (!i_cls.dig) again = 1'b1;
                end
                jsv_pkg::G_N_E: begin
                    if (c == "+" || c == "-") n_gs = jsv_pkg::G_N_ESIGN;
                    else if (i_cls.dig) n_gs = jsv_pkg::G_N_EXP;
                    else n_ls = jsv_pkg::ST_BAD;
                end
                jsv_pkg::G_N_ESIGN: begin
                    if (i_cls.dig) n_gs = jsv_pkg::G_N_EXP;
                    else n_ls = jsv_pkg::ST_BAD;
                end
                jsv_pkg::G_N_EXP: begin
                    if (!i_cls.dig) again = 1'b1;
                end
                jsv_pkg::G_LIT: begin
                    if (r_li < jsv_pkg::lit_len(r_lk) && c == jsv_pkg::lit_char(r_lk, r_li)) begin
                        n_li = r_li + 3'd1;
                        if (n_li >= jsv_pkg::lit_len(r_lk)) done_val = 1'b1;
                    end else n_ls = jsv_pkg::ST_BAD;
                end
                default: n_ls = jsv_pkg::ST_BAD;
            endcase
            // A number ended: recheck the byte as the one following a value
            if (again) begin
                if (r_lvl == '0) begin
                    n_gs = jsv_pkg::G_TRAIL;
                    if (!i_cls.ws) n_ls = jsv_pkg::ST_BAD;
                end else if (i_cls.ws) n_gs = jsv_pkg::G_AFTER;
                else if (c == ",") n_gs = r_top ? jsv_pkg::G_OBJ_KEY : jsv_pkg::G_VALUE;
                else if ((c == "}" && r_top) || (c == "]" && !r_top)) close_c = 1'b1;
                else begin
                    n_gs = jsv_pkg::G_AFTER;
                    n_ls = jsv_pkg::ST_BAD;
                end
            end
            if (open_c) begin
                if (c == "{" || c == "[") begin
                    if (r_lvl >= LW'(MAX_DEPTH)) n_ls = jsv_pkg::ST_DEEP;
                    else begin
                        w_push = 1'b1;
                        w_push_obj = (c == "{");
                        n_lvl = r_lvl + 1'b1;
                        n_top = (c == "{");
                        n_gs = (c == "{") ? jsv_pkg::G_OBJ_FIRST : jsv_pkg::G_ARR_FIRST;
                    end
                end else if (c == "\"") n_gs = jsv_pkg::G_STR_V;
                else if (c == "t" || c == "f" || c == "n") begin
                    n_lk = (c == "t") ? jsv_pkg::LIT_TRUE :
                           ((c == "f") ? jsv_pkg::LIT_FALSE : jsv_pkg::LIT_NULL);
                    n_li = 3'd1;
                    n_gs = jsv_pkg::G_LIT;
                end else if (c == "-") n_gs = jsv_pkg::G_N_MINUS;
                else if (c == "0") n_gs = jsv_pkg::G_N_ZERO;
                else if (i_cls.dig) n_gs = jsv_pkg::G_N_INT;
                else n_ls = jsv_pkg::ST_BAD;
            end
            if (close_c) begin
                n_lvl = r_lvl - 1'b1;
                done_val = 1'b1;
                n_top = (n_lvl != '0) ? r_below : 1'b0;
            end
            if (done_val) begin
                n_gs = (n_lvl == '0) ? jsv_pkg::G_TRAIL : jsv_pkg::G_AFTER;
            end
            if (n_ls != jsv_pkg::ST_RUN && !(n_ls == jsv_pkg::ST_UNI))
                n_epos = r_pos;
        end
        // Result for this byte
        if (n_ls != jsv_pkg::ST_RUN) begin
            n_ost = n_ls; n_opos = n_epos;
        end else if (!i_cls.eot) begin
            n_ost = jsv_pkg::ST_RUN; n_opos = 32'd0;
        end else if (n_gs == jsv_pkg::G_TOP) begin
            n_ost = jsv_pkg::ST_EMPTY; n_opos = 32'd0;
        end else if (n_gs == jsv_pkg::G_TRAIL ||
                     (n_lvl == '0 && (n_gs == jsv_pkg::G_N_ZERO || n_gs == jsv_pkg::G_N_INT ||
                      n_gs == jsv_pkg::G_N_FRAC || n_gs == jsv_pkg::G_N_EXP))) begin
            n_ost = jsv_pkg::ST_OK; n_opos = 32'd0;
        end else begin
            n_ost = jsv_pkg::ST_EARLY;
            n_opos = (r_pos == '1) ? r_pos : r_pos + 32'd1;
        end
    end

    // Stack holds the kind of each open container; top entry cached in r_top
    always_ff @(posedge i_clk) begin
        if (w_go && w_push) begin
            r_stk[AW'(r_lvl)] <= w_push_obj;
        end
        r_below <= r_stk[w_rd_addr];
        if (w_go) begin
            r_ost <= n_ost;
            r_opos <= n_opos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req <= 1'b1;
            r_ov <= 1'b0;
            r_gs <= jsv_pkg::G_TOP; r_lvl <= '0; r_li <= 3'd0; r_lk <= 2'd0;
            r_hc <= 3'd0; r_sur <= 1'b0; r_ls <= jsv_pkg::ST_RUN;
            r_pos <= 32'd0; r_epos <= 32'd0; r_top <= 1'b0;
        end else begin
            if (i_cfg_we) r_req <= i_cfg_wdata;
            if (w_go) r_ov <= 1'b1;
            else if (o_out.ready) r_ov <= 1'b0;
            if (w_go) begin
                if (i_cls.eot) begin
                    // Drop all document state for the next one
                    r_gs <= jsv_pkg::G_TOP; r_lvl <= '0; r_li <= 3'd0; r_lk <= 2'd0;
                    r_hc <= 3'd0; r_sur <= 1'b0; r_ls <= jsv_pkg::ST_RUN;
                    r_pos <= 32'd0; r_epos <= 32'd0; r_top <= 1'b0;
                end else begin
                    r_gs <= n_gs; r_lvl <= n_lvl; r_li <= n_li; r_lk <= n_lk;
                    r_hc <= n_hc; r_sur <= n_sur; r_ls <= n_ls; r_epos <= n_epos;
                    r_top <= n_top;
                    if (r_pos != '1) r_pos <= r_pos + 32'd1;
                end
            end
        end
    end
endmodule

// ===== dv/json_syntax_validator_unit_test.sv =====
// Testbench: byte-level predictor, scoreboard and random JSON stimulus for the validator.
module json_syntax_validator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import jsv_pkg::*;

    localparam int unsigned Depth = DefMaxDepth;
    localparam int CycleLimit = 400000;

    typedef bit [7:0] text_q_t[$];

    class json_scoreboard;
        typedef struct {
            t_status     st;
            logic [31:0] pos;
        } verdict_t;

        bit             require_container = 1'b1;
        t_gstate        gs;
        bit [Depth-1:0] stack;
        int unsigned    level;
        int             lit_idx;
        int             lit_kind;
        int             hex_cnt;
        bit             surrogate;
        t_status        latched;
        bit [31:0]      pos;
        bit [31:0]      err_pos;
        verdict_t       verdict_q[$];
        int             errors;
        string          lit_names[3] = '{"true", "false", "null"};

        function new();
            errors = 0;
            clear_doc();
        endfunction

        function void clear_doc();
            gs = G_TOP;
            stack = '0;
            level = 0;
            lit_idx = 0;
            lit_kind = 0;
            hex_cnt = 0;
            surrogate = 1'b0;
            latched = ST_RUN;
            pos = '0;
            err_pos = '0;
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        function void fail(t_status code, bit [31:0] at);
            if (latched == ST_RUN) begin
                latched = code;
                err_pos = at;
            end
        endfunction

        function void value_done();
            gs = (level == 0) ? G_TRAIL : G_AFTER;
        endfunction

        function bit top_obj();
            return level > 0 && level <= Depth && stack[level-1];
        endfunction

        function bit is_ws(bit [7:0] c);
            return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
        endfunction

        function int hexv(bit [7:0] c);
            if (c >= "0" && c <= "9") return c - "0";
            if (c >= "a" && c <= "f") return c - "a" + 10;
            if (c >= "A" && c <= "F") return c - "A" + 10;
            return -1;
        endfunction

        function void start_value(bit [7:0] c);
            if (c == "{" || c == "[") begin
                if (level >= Depth) begin
                    fail(ST_DEEP, pos);
                    return;
                end
                stack[level] = (c == "{");
                level++;
                gs = (c == "{") ? G_OBJ_FIRST : G_ARR_FIRST;
            end else if (c == "\"") begin
                gs = G_STR_V;
            end else if (c == "t" || c == "f" || c == "n") begin
                lit_kind = (c == "t") ? 0 : ((c == "f") ? 1 : 2);
                lit_idx = 1;
                gs = G_LIT;
            end else if (c == "-") begin
                gs = G_N_MINUS;
            end else if (c == "0") begin
                gs = G_N_ZERO;
            end else if (c >= "1" && c <= "9") begin
                gs = G_N_INT;
            end else begin
                fail(ST_BAD, pos);
            end
        endfunction

        function void close_container();
            level--;
            value_done();
        endfunction

        function void string_byte(bit [7:0] c, bit key);
            if (c == "\"") begin
                if (key) gs = G_COLON;
                else value_done();
            end else if (c <= 8'd31) begin
                fail(ST_CTRL, pos);
            end else if (c == "\\") begin
                gs = key ? G_ESC_K : G_ESC_V;
            end
        endfunction

        function void escape_byte(bit [7:0] c, bit key);
            if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
                c == "n" || c == "r" || c == "t") begin
                gs = key ? G_STR_K : G_STR_V;
            end else if (c == "u") begin
                hex_cnt = 0;
                surrogate = 1'b0;
                gs = key ? G_HEX_K : G_HEX_V;
            end else begin
                fail(ST_BAD, pos);
            end
        endfunction

        function void hex_byte(bit [7:0] c, bit key);
            int v;
            v = hexv(c);
            if (v < 0) begin
                fail(ST_BAD, pos);
                return;
            end
            if (hex_cnt == 0) surrogate = (v == 13);
            else if (hex_cnt == 1) surrogate = surrogate && v >= 8;
            hex_cnt++;
            if (hex_cnt >= 4) begin
                hex_cnt = 0;
                if (surrogate) begin
                    fail(ST_UNI, pos - 32'd4);
                    return;
                end
                gs = key ? G_STR_K : G_STR_V;
            end
        endfunction

        // Returns 1 when the byte closed a number and must be looked at again.
        function bit advance(bit [7:0] c);
            bit dig;
            bit expo;
            dig = c >= "0" && c <= "9";
            expo = c == "e" || c == "E";
            case (gs)
                G_TOP: begin
                    if (!is_ws(c)) begin
                        if (require_container && c != "{" && c != "[") fail(ST_BAD, pos);
                        else start_value(c);
                    end
                end
                G_VALUE: if (!is_ws(c)) start_value(c);
                G_ARR_FIRST: begin
                    if (!is_ws(c)) begin
                        if (c == "]") close_container();
                        else start_value(c);
                    end
                end
                G_OBJ_FIRST, G_OBJ_KEY: begin
                    if (!is_ws(c)) begin
                        if (c == "\"") gs = G_STR_K;
                        else if (c == "}" && gs == G_OBJ_FIRST) close_container();
                        else fail(ST_BAD, pos);
                    end
                end
                G_COLON: begin
                    if (!is_ws(c)) begin
                        if (c == ":") gs = G_VALUE;
                        else fail(ST_BAD, pos);
                    end
                end
                G_AFTER: begin
                    if (!is_ws(c)) begin
                        if (level == 0) fail(ST_BAD, pos);
                        else if (c == ",") gs = top_obj() ? G_OBJ_KEY : G_VALUE;
                        else if (c == "}" && top_obj()) close_container();
                        else if (c == "]" && !top_obj()) close_container();
                        else fail(ST_BAD, pos);
                    end
                end
                G_TRAIL: if (!is_ws(c)) fail(ST_BAD, pos);
                G_STR_V: string_byte(c, 1'b0);
                G_STR_K: string_byte(c, 1'b1);
                G_ESC_V: escape_byte(c, 1'b0);
                G_ESC_K: escape_byte(c, 1'b1);
                G_HEX_V: hex_byte(c, 1'b0);
                G_HEX_K: hex_byte(c, 1'b1);
                G_N_MINUS: begin
                    if (c == "0") gs = G_N_ZERO;
                    else if (dig) gs = G_N_INT;
                    else fail(ST_BAD, pos);
                end
                G_N_ZERO, G_N_INT: begin
                    if (dig && gs == G_N_ZERO) fail(ST_BAD, pos);
                    else if (!dig) begin
                        if (c == ".") gs = G_N_DOT;
                        else if (expo) gs = G_N_E;
                        else begin
                            value_done();
                            return 1'b1;
                        end
                    end
                end
                G_N_DOT: begin
                    if (dig) gs = G_N_FRAC;
                    else fail(ST_BAD, pos);
                end
                G_N_FRAC: begin
                    if (!dig) begin
                        if (expo) gs = G_N_E;
                        else begin
                            value_done();
                            return 1'b1;
                        end
                    end
                end
                G_N_E: begin
                    if (c == "+" || c == "-") gs = G_N_ESIGN;
                    else if (dig) gs = G_N_EXP;
                    else fail(ST_BAD, pos);
                end
                G_N_ESIGN: begin
                    if (dig) gs = G_N_EXP;
                    else fail(ST_BAD, pos);
                end
                G_N_EXP: begin
                    if (!dig) begin
                        value_done();
                        return 1'b1;
                    end
                end
                G_LIT: begin
                    if (lit_idx < lit_names[lit_kind].len() &&
                        c == lit_names[lit_kind][lit_idx]) begin
                        lit_idx++;
                        if (lit_idx >= lit_names[lit_kind].len()) value_done();
                    end else begin
                        fail(ST_BAD, pos);
                    end
                end
                default: fail(ST_BAD, pos);
            endcase
            return 1'b0;
        endfunction

        function void note_byte(bit [7:0] c, bit eot);
            verdict_t v;
            if (latched == ST_RUN) begin
                if (advance(c) && latched == ST_RUN) void'(advance(c));
            end
            if (latched != ST_RUN) begin
                v.st = latched;
                v.pos = err_pos;
            end else if (!eot) begin
                v.st = ST_RUN;
                v.pos = '0;
            end else if (gs == G_TOP) begin
                v.st = ST_EMPTY;
                v.pos = '0;
            end else if (gs == G_TRAIL || (level == 0 && (gs == G_N_ZERO ||
                         gs == G_N_INT || gs == G_N_FRAC || gs == G_N_EXP))) begin
                v.st = ST_OK;
                v.pos = '0;
            end else begin
                v.st = ST_EARLY;
                v.pos = (pos == '1) ? pos : pos + 32'd1;
            end
            verdict_q.push_back(v);
            if (pos != '1) pos++;
            if (eot) clear_doc();
        endfunction

        function void check_result(logic [2:0] st, logic [31:0] at);
            verdict_t v;
            if (verdict_q.size() == 0) begin
                $error("result with nothing expected: status %0d position %0d", st, at);
                errors++;
                return;
            end
            v = verdict_q.pop_front();
            if (st !== v.st) begin
                $error("status: expected %0d, actual %0d", v.st, st);
                errors++;
            end
            if (at !== v.pos) begin
                $error("error_position: expected %0d, actual %0d", v.pos, at);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    jsv_in_if  u_in ();
    jsv_out_if u_out ();

    json_syntax_validator_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (u_in),
        .o_out       (u_out)
    );

    json_scoreboard sb = new();
    bit             no_idle;
    int             bytes_sent;
    int             cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        u_in.valid = 1'b0;
        u_in.text_byte = 8'h00;
        u_in.end_of_text = 1'b0;
        u_out.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("json_syntax_validator_unit_test: done, errors");
            $finish;
        end
    end

    // Result side: random stalls; each transaction is checked at the rising edge that takes it.
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 14);
            repeat (gap) begin
                @(negedge i_clk);
                u_out.ready = 1'b0;
            end
            @(negedge i_clk);
            u_out.ready = 1'b1;
            do @(posedge i_clk); while (!u_out.valid);
            sb.check_result(u_out.status, u_out.error_position);
        end
    end

    task automatic send_doc(text_q_t doc);
        int gap;
        foreach (doc[i]) begin
            gap = no_idle ? 0 : $urandom_range(0, 14);
            repeat (gap) begin
                @(negedge i_clk);
                u_in.valid = 1'b0;
            end
            @(negedge i_clk);
            u_in.valid = 1'b1;
            u_in.text_byte = doc[i];
            u_in.end_of_text = (i == doc.size() - 1);
            do @(posedge i_clk); while (!u_in.ready);
            sb.note_byte(doc[i], i == doc.size() - 1);
            bytes_sent++;
        end
        @(negedge i_clk);
        u_in.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_require(bit value);
        wait_drained();
        repeat (4) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.require_container = value;
    endtask

    function automatic text_q_t to_text(string s);
        text_q_t q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    function automatic void add_ws(ref text_q_t q);
        bit [7:0] ws_set[6] = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 2)) q.push_back(ws_set[$urandom_range(0, 5)]);
        end
    endfunction

    function automatic void add_string(ref text_q_t q);
        string simple = "\"\\/bfnrt";
        string hexs = "0123456789abcdefABCDEF";
        bit [7:0] c;
        q.push_back("\"");
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 9))
                0: begin
                    q.push_back("\\");
                    q.push_back(simple[$urandom_range(0, simple.len() - 1)]);
                end
                1: begin
                    q.push_back("\\");
                    q.push_back("u");
                    // bias the leading digits towards the surrogate range
                    if ($urandom_range(0, 2) == 0) begin
                        q.push_back($urandom_range(0, 1) ? "d" : "D");
                        q.push_back(hexs[$urandom_range(6, 13)]);
                    end else begin
                        q.push_back(hexs[$urandom_range(0, 21)]);
                        q.push_back(hexs[$urandom_range(0, 21)]);
                    end
                    q.push_back(hexs[$urandom_range(0, 21)]);
                    q.push_back(hexs[$urandom_range(0, 21)]);
                end
                2: q.push_back($urandom_range(127, 255));
                default: begin
                    c = $urandom_range(32, 126);
                    if (c == "\"" || c == "\\") c = "a";
                    q.push_back(c);
                end
            endcase
        end
        q.push_back("\"");
    endfunction

    function automatic void add_number(ref text_q_t q);
        if ($urandom_range(0, 2) == 0) q.push_back("-");
        if ($urandom_range(0, 3) == 0) q.push_back("0");
        else begin
            q.push_back($urandom_range("1", "9"));
            repeat ($urandom_range(0, 3)) q.push_back($urandom_range("0", "9"));
        end
        if ($urandom_range(0, 2) == 0) begin
            q.push_back(".");
            repeat ($urandom_range(1, 3)) q.push_back($urandom_range("0", "9"));
        end
        if ($urandom_range(0, 2) == 0) begin
            q.push_back($urandom_range(0, 1) ? "e" : "E");
            case ($urandom_range(0, 2))
                0: q.push_back("+");
                1: q.push_back("-");
                default: ;
            endcase
            repeat ($urandom_range(1, 2)) q.push_back($urandom_range("0", "9"));
        end
    endfunction

    function automatic void add_value(ref text_q_t q, input int depth, input bit container);
        int kind;
        int n;
        string lits[3] = '{"true", "false", "null"};
        kind = container ? $urandom_range(0, 1) : $urandom_range(0, 5);
        if (depth >= 4 && kind < 2) kind = 2;
        add_ws(q);
        case (kind)
            0, 1: begin
                n = $urandom_range(0, 3);
                q.push_back(kind == 0 ? "{" : "[");
                for (int i = 0; i < n; i++) begin
                    if (i > 0) q.push_back(",");
                    if (kind == 0) begin
                        add_ws(q);
                        add_string(q);
                        add_ws(q);
                        q.push_back(":");
                    end
                    add_value(q, depth + 1, 1'b0);
                end
                add_ws(q);
                q.push_back(kind == 0 ? "}" : "]");
            end
            2: add_string(q);
            3: add_number(q);
            default: begin
                n = $urandom_range(0, 2);
                for (int i = 0; i < lits[n].len(); i++) q.push_back(lits[n][i]);
            end
        endcase
        add_ws(q);
    endfunction

    function automatic text_q_t random_doc();
        text_q_t q;
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            repeat ($urandom_range(1, 8)) q.push_back($urandom_range(0, 255));
            return q;
        end
        add_value(q, 0, sb.require_container ? 1'b1 : ($urandom_range(0, 3) == 0));
        if (r < 20) q[$urandom_range(0, q.size() - 1)] = $urandom_range(0, 255);
        else if (r < 26 && q.size() > 1) q = q[0:$urandom_range(0, q.size() - 2)];
        else if (r < 30) q.push_back($urandom_range(33, 126));
        return q;
    endfunction

    task automatic random_phase(int until_bytes);
        int docs;
        docs = 0;
        while (bytes_sent < until_bytes) begin
            if ($urandom_range(0, 4) == 0) no_idle = ~no_idle;
            send_doc(random_doc());
            docs++;
            // hold off once until everything in flight has drained
            if (docs == 6) wait_drained();
        end
    endtask

    initial begin
        string d1[16] = '{"{}", "[ ]", " \t", "[1,]", "{\"a\":1,}", "[01]",
                          "[-0.5e+10,0E-1]", "[\"\\ud800\"]", "[\"\\q\"]",
                          "[\"\\u12g4\"]", "[\"\001\"]", "[1] x", "[tru",
                          "{\"a\" 1}", "[true,false,null,\"\\u00ff\\/\"]", "5"};
        string d0[6] = '{"5", "\"x\\n\"", "-", "0", "null ", "1.5e3"};
        text_q_t deep;
        cycles = 0;
        bytes_sent = 0;
        no_idle = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (d1[i]) send_doc(to_text(d1[i]));
        send_doc('{"[", "\"", 8'hff, 8'h80, "\"", "]"});
        write_require(1'b0);
        foreach (d0[i]) send_doc(to_text(d0[i]));
        random_phase(230);
        write_require(1'b1);
        repeat (Depth + 1) deep.push_back("[");
        send_doc(deep);
        random_phase(430);
        write_require(1'b0);
        random_phase(500);
        write_require(1'b1);
        random_phase(550);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.pending() != 0) $error("%0d results never arrived", sb.pending());
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("json_syntax_validator_unit_test: done, clean");
        end else begin
            $display("json_syntax_validator_unit_test: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/jsv_pkg.sv
src/jsv_if.sv
src/jsv_front.sv
src/jsv_back.sv
src/json_syntax_validator_unit.sv
dv/json_syntax_validator_unit_test.sv
